@@ rtl/core/bta_pkg.sv @@
// Shared types and constants for the tracked bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
package bta_pkg;

  localparam int BITS_DEFAULT = 1024;
  localparam int WORD_W       = 32;
  localparam int OFF_W        = $clog2(WORD_W);

  localparam int CMD_W   = 2;
  localparam int INDEX_W = 10;
  localparam int LS_W    = 11;
  localparam int LC_W    = 11;
  localparam int HS_W    = 10;

  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;

  typedef struct packed {
    logic             want;   // bit value looked for
    logic             dn;     // scan toward lower indices
    logic             first;  // row holds the scan start, apply offset mask
    logic             tail;   // last row, drop positions past the bitmap end
    logic [OFF_W-1:0] off;    // start offset in the first row
  } find_req_t;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] pos;
  } find_res_t;

endpackage
`default_nettype wire

@@ rtl/core/bta_store.sv @@
// Bitmap word memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bta_store #(
  parameter int ROWS = 32,
  parameter int RW   = 5
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [RW-1:0]             waddr,
  input  logic [bta_pkg::WORD_W-1:0] wdata,
  input  logic [RW-1:0]             raddr,
  output logic [bta_pkg::WORD_W-1:0] rdata
);
  import bta_pkg::*;

  logic [WORD_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/bta_find.sv @@
// Shared find unit: first matching bit of one word, upward or downward.
`timescale 1ns / 1ps
`default_nettype none
module bta_find #(
  parameter int TAIL = 0
) (
  input  logic [bta_pkg::WORD_W-1:0] word,
  input  bta_pkg::find_req_t         req,
  output bta_pkg::find_res_t         res
);
  import bta_pkg::*;

  logic [WORD_W-1:0] hit;
  logic [WORD_W-1:0] ord;
  logic [OFF_W-1:0]  pos;

  // mask candidates: wanted value, start offset, bitmap end
  always_comb begin
    for (int p = 0; p < WORD_W; p++) begin
      hit[p] = (word[p] == req.want);
      if (req.first) begin
        if (req.dn) begin
          hit[p] = hit[p] && (OFF_W'(p) < req.off);
        end else begin
          hit[p] = hit[p] && (OFF_W'(p) >= req.off);
        end
      end
      if (req.tail && (TAIL != 0) && (p >= TAIL)) begin
        hit[p] = 1'b0;
      end
    end
  end

  // downward scans reuse the same lowest-first encoder on a reversed word
  always_comb begin
    for (int p = 0; p < WORD_W; p++) begin
      ord[p] = req.dn ? hit[WORD_W-1-p] : hit[p];
    end
  end

  always_comb begin
    pos = '0;
    for (int p = WORD_W - 1; p >= 0; p--) begin
      if (ord[p]) begin
        pos = OFF_W'(p);
      end
    end
    res.found = |ord;
    res.pos   = req.dn ? (OFF_W'(WORD_W - 1) - pos) : pos;
  end

endmodule
`default_nettype wire

@@ rtl/core/tracked_bitmap_allocator_top.sv @@
// Top level of the tracked bitmap allocator: sequencer, index registers, ports.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready | s_tdata: cmd, bit_index
//  m_*     | out | m_tvalid/m_tready | m_tdata: bit_value, lowest_set,
//          |     |                   |         lowest_clear, highest_set
//
// One command at a time. Accept, then the read-modify-write of the addressed
// word in the modify state, then the result register. A scan adds an issue
// state, then visits one 32-bit word at a time through the single read port
// of the word memory and the shared find unit; a clear may run an upward and
// a downward scan back to back. After reset a clearing pass writes every word
// to zero, with s_tready low. The result waits in its register for m_tready;
// s_tready is low until that transfer completes.
`timescale 1ns / 1ps
`default_nettype none
module tracked_bitmap_allocator_top #(
  parameter int BITS = bta_pkg::BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [bta_pkg::S_DATA_W-1:0] s_tdata,  // [1:0] cmd, [11:2] bit_index
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [bta_pkg::M_DATA_W-1:0] m_tdata   // [0] bit_value, [11:1] lowest_set,
                                                 // [22:12] lowest_clear,
                                                 // [32:23] highest_set
);
  import bta_pkg::*;

  localparam int XW       = $clog2(BITS);             // bit index
  localparam int IW       = XW + 1;                   // index or "none"
  localparam int RW       = XW - OFF_W;               // word address
  localparam int ROWS     = (BITS + WORD_W - 1) / WORD_W;
  localparam int TAIL     = BITS % WORD_W;
  localparam int LAST_ROW = ROWS - 1;

  localparam logic [IW-1:0] NONE_I = IW'(BITS);
  localparam logic [RW-1:0] LAST_R = RW'(LAST_ROW);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MOD,
    ST_SCAN_ISSUE,
    ST_SCAN,
    ST_OUT
  } state_t;

  state_t            state;
  logic [CMD_W-1:0]  cmd_q;
  logic [XW-1:0]     idx;
  logic              bit_value;
  logic [IW-1:0]     lo_set;
  logic [IW-1:0]     lo_clr;
  logic [XW-1:0]     hi_set;
  logic              pend_dn;
  logic              scan_dn;
  logic              scan_want;
  logic              scan_first;
  logic [RW-1:0]     scan_row;
  logic [RW-1:0]     clr_row;

  // input fields
  logic [CMD_W-1:0]   cmd_in;
  logic [INDEX_W-1:0] bit_index;
  logic [XW-1:0]      idx_in;
  logic               in_range;

  assign cmd_in    = s_tdata[CMD_W-1:0];
  assign bit_index = s_tdata[CMD_W+INDEX_W-1:CMD_W];
  assign idx_in    = XW'(bit_index);
  assign in_range  = 32'(bit_index) < 32'(BITS);

  // index arithmetic around the addressed bit
  logic [IW-1:0]     idx_ext;
  logic [IW-1:0]     succ;
  logic              succ_end;
  logic [OFF_W-1:0]  cur_off;
  logic [RW-1:0]     cur_row;
  logic [RW-1:0]     start_row;
  logic [OFF_W-1:0]  start_off;

  assign idx_ext   = IW'(idx);
  assign succ      = idx_ext + IW'(1);
  assign succ_end  = (succ == NONE_I);
  assign cur_off   = idx[OFF_W-1:0];
  assign cur_row   = idx[XW-1:OFF_W];
  assign start_row = scan_dn ? cur_row : succ[XW-1:OFF_W];
  assign start_off = scan_dn ? cur_off : succ[OFF_W-1:0];

  // word memory
  logic              we;
  logic [RW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic [RW-1:0]     raddr;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] new_word;

  // test and the spare code leave the word as read
  always_comb begin
    new_word = rdata;
    if (cmd_q == CMD_SET) begin
      new_word[cur_off] = 1'b1;
    end else if (cmd_q == CMD_CLEAR) begin
      new_word[cur_off] = 1'b0;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_row;
    wdata = new_word;
    unique case (state)
      ST_INIT: begin
        we    = 1'b1;
        waddr = clr_row;
        wdata = '0;
      end
      ST_MOD: begin
        we = (cmd_q == CMD_SET) || (cmd_q == CMD_CLEAR);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // read is issued in the cycle before its use
  always_comb begin
    unique case (state)
      ST_IDLE:       raddr = idx_in[XW-1:OFF_W];
      ST_SCAN_ISSUE: raddr = start_row;
      ST_SCAN:       raddr = scan_dn ? (scan_row - RW'(1)) : (scan_row + RW'(1));
      default:       raddr = '0;
    endcase
  end

  bta_store #(
    .ROWS (ROWS),
    .RW   (RW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared find unit
  find_req_t freq;
  find_res_t fres;

  assign freq.want  = scan_dn ? 1'b1 : scan_want;
  assign freq.dn    = scan_dn;
  assign freq.first = scan_first;
  assign freq.tail  = !scan_dn && (scan_row == LAST_R);
  assign freq.off   = start_off;

  bta_find #(
    .TAIL (TAIL)
  ) u_find (
    .word (rdata),
    .req  (freq),
    .res  (fres)
  );

  // scan bookkeeping
  logic          scan_done;
  logic [IW-1:0] scan_val;

  assign scan_done = fres.found || (!scan_dn && (scan_row == LAST_R)) ||
                     (scan_dn && (scan_row == '0));
  assign scan_val  = fres.found ? IW'({scan_row, fres.pos}) :
                     (scan_dn ? '0 : NONE_I);

  // which tracked indices the modify step invalidates
  logic set_hit_clr;
  logic clr_hit_ls;
  logic clr_hit_hs;
  logic need_up;
  logic need_dn;

  assign set_hit_clr = (cmd_q == CMD_SET) && (idx_ext == lo_clr);
  assign clr_hit_ls  = (cmd_q == CMD_CLEAR) && (idx_ext == lo_set);
  assign clr_hit_hs  = (cmd_q == CMD_CLEAR) && (idx == hi_set);
  assign need_up     = (set_hit_clr || clr_hit_ls) && !succ_end;
  assign need_dn     = clr_hit_hs && (idx != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INIT;
      clr_row <= '0;
      lo_set  <= NONE_I;
      lo_clr  <= '0;
      hi_set  <= '0;
      pend_dn <= 1'b0;
    end else begin
      unique case (state)
        ST_INIT: begin
          clr_row <= clr_row + RW'(1);
          if (clr_row == LAST_R) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_q <= cmd_in;
            idx   <= idx_in;
            if (in_range) begin
              state <= ST_MOD;
            end else begin
              bit_value <= 1'b0;
              state     <= ST_OUT;
            end
          end
        end
        ST_MOD: begin
          bit_value <= new_word[cur_off];
          if (cmd_q == CMD_SET) begin
            if (idx_ext < lo_set) begin
              lo_set <= idx_ext;
            end
            if (idx > hi_set) begin
              hi_set <= idx;
            end
            if (set_hit_clr && succ_end) begin
              lo_clr <= NONE_I;
            end
          end else if (cmd_q == CMD_CLEAR) begin
            if (idx_ext < lo_clr) begin
              lo_clr <= idx_ext;
            end
            if (clr_hit_ls && succ_end) begin
              lo_set <= NONE_I;
            end
            if (clr_hit_hs && (idx == '0)) begin
              hi_set <= '0;
            end
          end
          scan_want <= clr_hit_ls;
          if (need_up) begin
            scan_dn <= 1'b0;
            pend_dn <= need_dn;
            state   <= ST_SCAN_ISSUE;
          end else if (need_dn) begin
            scan_dn <= 1'b1;
            pend_dn <= 1'b0;
            state   <= ST_SCAN_ISSUE;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_SCAN_ISSUE: begin
          scan_row   <= start_row;
          scan_first <= 1'b1;
          state      <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_done) begin
            if (scan_dn) begin
              hi_set <= XW'(scan_val);
            end else if (scan_want) begin
              lo_set <= scan_val;
            end else begin
              lo_clr <= scan_val;
            end
            if (pend_dn) begin
              scan_dn <= 1'b1;
              pend_dn <= 1'b0;
              state   <= ST_SCAN_ISSUE;
            end else begin
              state <= ST_OUT;
            end
          end else begin
            scan_row   <= raddr;
            scan_first <= 1'b0;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_INIT;
        end
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {
    (M_DATA_W - 1 - LS_W - LC_W - HS_W)'(0),
    HS_W'(hi_set),
    LC_W'(lo_clr),
    LS_W'(lo_set),
    bit_value
  };

endmodule
`default_nettype wire

@@ rtl/core/bta_checker.sv @@
// Port-level checks for the tracked bitmap allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bta_checker #(
  parameter int BITS = bta_pkg::BITS_DEFAULT
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [bta_pkg::S_DATA_W-1:0] s_tdata,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [bta_pkg::M_DATA_W-1:0] m_tdata
);
  import bta_pkg::*;

  logic [LS_W-1:0] ls;
  logic [HS_W-1:0] hs;
  logic [S_DATA_W-1:0] unused_sdata;

  assign ls = m_tdata[LS_W:1];
  assign hs = m_tdata[LS_W+LC_W+HS_W:LS_W+LC_W+1];
  assign unused_sdata = s_tdata;

  // one command in flight: never ready while a result is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after accept");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (32'(ls) < 32'(BITS))) |-> (32'(ls) <= 32'(hs)))
    else $error("lowest set above highest set");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (32'(ls) == 32'(BITS))) |-> (hs == '0))
    else $error("highest set nonzero with empty bitmap");

endmodule

bind tracked_bitmap_allocator_top bta_checker #(
  .BITS (BITS)
) u_bta_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
